>>> design/assert_macros.svh
// Assertion macros shared by the console's modules.
// Each macro expects the signals clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CLCD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An implication: whenever pre holds, post must hold in the same cycle.
`define CLCD_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

>>> design/clcd_pkg.sv
// Package for the character LCD text console: constants, codes and the
// transaction and controller interface types. Depends on nothing.
package clcd_pkg;

	localparam int COLUMNS_DEF = 16;
	localparam int ROWS_DEF    = 2;

	localparam logic [7:0] NEWLINE        = 8'd10;
	localparam logic [7:0] CRETURN        = 8'd13;
	localparam logic [7:0] BLANK          = 8'h20;
	localparam logic [6:0] ROW_OFFSET_RST = 7'd64;

	// Request operation codes.
	localparam logic [1:0] OP_PRINT  = 2'd0;
	localparam logic [1:0] OP_LOCATE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// LCD bus command kinds.
	localparam logic [1:0] KIND_ADDR  = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] char_code;
		logic [3:0] target_column;
		logic       target_row;
	} clcd_req_t;

	typedef struct packed {
		logic [1:0] command_kind;
		logic [7:0] command_value;
		logic       last_command;
	} clcd_bus_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_HOME,
		ST_SCAN_RD,
		ST_SCAN_WR,
		ST_CHAR,
		ST_CLEAR
	} clcd_state_t;

	// Which command the datapath puts on the bus.
	typedef enum logic [2:0] {
		SEL_CUR_ADDR,
		SEL_HOME_ADDR,
		SEL_CHAR,
		SEL_SCAN,
		SEL_CLEAR
	} clcd_sel_t;

	typedef struct packed {
		logic      take_print;
		logic      take_locate;
		logic      take_clear;
		logic      put_char;
		logic      scan_start;
		logic      scan_read;
		logic      scan_write;
		clcd_sel_t sel;
		logic      last;
	} clcd_cmd_t;

	typedef struct packed {
		logic wrap_due;
		logic last_row;
		logic printable;
		logic scan_done;
	} clcd_sts_t;

endpackage

>>> design/clcd_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module clcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> design/clcd_dp.sv
// Datapath of the text console: cursor, previous character, row offset,
// shadow screen store with its valid bits, and bus command formation.
// Depends on clcd_pkg, clcd_ram and assert_macros.svh.
`include "assert_macros.svh"

module clcd_dp
	import clcd_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	input  clcd_req_t req,
	input  clcd_cmd_t cmd,
	output clcd_sts_t sts,
	output clcd_bus_t bus
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int IDX_W = $clog2(CELLS);
	localparam int COL_W = $clog2(COLUMNS + 1);
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int PW    = ROW_W + 7;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [7:0]       prev_q;
	logic [6:0]       off_q;
	logic [7:0]       ch_q;
	logic [IDX_W-1:0] scan_q;
	logic [CELLS-1:0] vld_q;
	logic             vld_rd_q;

	logic [COL_W-1:0] loc_col;
	logic [ROW_W-1:0] loc_row;
	logic [PW-1:0]    roff_prod;
	logic [7:0]       cur_addr;
	logic [IDX_W-1:0] cell_idx;
	logic             from_top;
	logic [IDX_W-1:0] rd_idx;
	logic [7:0]       rd_data;
	logic [7:0]       scan_val;
	logic             ram_we;
	logic [IDX_W-1:0] wr_idx;
	logic [7:0]       wr_val;

	assign loc_col = (COL_W'(req.target_column) > COL_W'(COLUMNS)) ?
		COL_W'(COLUMNS) : COL_W'(req.target_column);
	assign loc_row = (ROW_W'(req.target_row) > ROW_W'(ROWS - 1)) ?
		ROW_W'(ROWS - 1) : ROW_W'(req.target_row);

	assign roff_prod = PW'(row_q) * PW'(off_q);
	assign cur_addr  = 8'(col_q) + roff_prod[7:0];
	assign cell_idx  = IDX_W'(col_q) + IDX_W'(int'(row_q) * COLUMNS);

	// During a scroll, rows below the top move up; the last row is blanked.
	assign from_top = (scan_q < IDX_W'(CELLS - COLUMNS));
	assign rd_idx   = scan_q + IDX_W'(COLUMNS);
	assign scan_val = (from_top && vld_rd_q) ? rd_data : BLANK;

	assign ram_we = cmd.put_char | cmd.scan_write;
	assign wr_idx = cmd.put_char ? cell_idx : scan_q;
	assign wr_val = cmd.put_char ? ch_q : scan_val;

	clcd_ram #(
		.WIDTH(8),
		.DEPTH(CELLS)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(wr_idx),
		.wr_data(wr_val),
		.rd_en  (cmd.scan_read),
		.rd_addr(rd_idx),
		.rd_data(rd_data)
	);

	assign sts.wrap_due  = (prev_q == NEWLINE) || (col_q >= COL_W'(COLUMNS));
	assign sts.last_row  = (row_q == ROW_W'(ROWS - 1));
	assign sts.printable = (req.char_code != NEWLINE) && (req.char_code != CRETURN);
	assign sts.scan_done = (scan_q == IDX_W'(CELLS - 1));

	always_comb begin
		bus.last_command = cmd.last;
		unique case (cmd.sel)
			SEL_CUR_ADDR: begin
				bus.command_kind  = KIND_ADDR;
				bus.command_value = cur_addr;
			end
			SEL_HOME_ADDR: begin
				bus.command_kind  = KIND_ADDR;
				bus.command_value = 8'd0;
			end
			SEL_CHAR: begin
				bus.command_kind  = KIND_DATA;
				bus.command_value = ch_q;
			end
			SEL_SCAN: begin
				bus.command_kind  = KIND_DATA;
				bus.command_value = scan_val;
			end
			SEL_CLEAR: begin
				bus.command_kind  = KIND_CLEAR;
				bus.command_value = 8'd0;
			end
			default: begin
				bus.command_kind  = KIND_CLEAR;
				bus.command_value = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			prev_q <= '0;
			off_q  <= ROW_OFFSET_RST;
			vld_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				off_q <= cfg_wr_data;
			end
			if (cmd.take_clear) begin
				col_q  <= '0;
				row_q  <= '0;
				prev_q <= '0;
			end else if (cmd.take_locate) begin
				col_q  <= loc_col;
				row_q  <= loc_row;
				prev_q <= '0;
			end else if (cmd.take_print) begin
				prev_q <= req.char_code;
				if (sts.wrap_due) begin
					col_q <= '0;
					if (!sts.last_row) begin
						row_q <= row_q + ROW_W'(1);
					end
				end
			end else if (cmd.put_char) begin
				col_q <= col_q + COL_W'(1);
			end
			if (cmd.take_clear) begin
				vld_q <= '0;
			end else if (ram_we) begin
				vld_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_print) begin
			ch_q <= req.char_code;
		end
		if (cmd.scan_start) begin
			scan_q <= '0;
		end else if (cmd.scan_write) begin
			scan_q <= scan_q + IDX_W'(1);
		end
		if (cmd.scan_read) begin
			vld_rd_q <= vld_q[rd_idx];
		end
	end

	`CLCD_ASSERT_IMPL(a_char_in_row, cmd.put_char, col_q < COL_W'(COLUMNS),
		"character written past row end")
	`CLCD_ASSERT(a_row_range, row_q <= ROW_W'(ROWS - 1), "cursor row beyond last row")
	`CLCD_ASSERT_IMPL(a_scan_range, cmd.scan_write, scan_q <= IDX_W'(CELLS - 1),
		"scroll index out of range")

endmodule

>>> design/clcd_ctrl.sv
// Controller state machine of the text console: accepts requests and
// sequences the bus commands. Depends on clcd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module clcd_ctrl
	import clcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_operation,
	input  clcd_sts_t  sts,
	input  logic       bus_ready,
	output logic       req_ready,
	output logic       bus_valid,
	output clcd_cmd_t  cmd
);

	clcd_state_t state_q, state_d;
	logic        char_due_q, char_due_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			char_due_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			char_due_q <= char_due_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		char_due_d = char_due_q;
		req_ready  = 1'b0;
		bus_valid  = 1'b0;
		cmd        = '{default: '0, sel: SEL_CUR_ADDR};
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					unique case (req_operation)
						OP_PRINT: begin
							cmd.take_print = 1'b1;
							char_due_d     = sts.printable;
							if (sts.wrap_due) begin
								state_d = sts.last_row ? ST_HOME : ST_ADDR;
							end else if (sts.printable) begin
								state_d = ST_CHAR;
							end
						end
						OP_LOCATE: begin
							cmd.take_locate = 1'b1;
							char_due_d      = 1'b0;
							state_d         = ST_ADDR;
						end
						OP_CLEAR: begin
							cmd.take_clear = 1'b1;
							state_d        = ST_CLEAR;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_ADDR: begin
				bus_valid = 1'b1;
				cmd.sel   = SEL_CUR_ADDR;
				cmd.last  = !char_due_q;
				if (bus_ready) begin
					state_d = char_due_q ? ST_CHAR : ST_IDLE;
				end
			end
			ST_HOME: begin
				bus_valid = 1'b1;
				cmd.sel   = SEL_HOME_ADDR;
				if (bus_ready) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				cmd.sel       = SEL_SCAN;
				cmd.scan_read = 1'b1;
				state_d       = ST_SCAN_WR;
			end
			ST_SCAN_WR: begin
				bus_valid = 1'b1;
				cmd.sel   = SEL_SCAN;
				if (bus_ready) begin
					cmd.scan_write = 1'b1;
					state_d        = sts.scan_done ? ST_ADDR : ST_SCAN_RD;
				end
			end
			ST_CHAR: begin
				bus_valid = 1'b1;
				cmd.sel   = SEL_CHAR;
				cmd.last  = 1'b1;
				if (bus_ready) begin
					cmd.put_char = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				bus_valid = 1'b1;
				cmd.sel   = SEL_CLEAR;
				cmd.last  = 1'b1;
				if (bus_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`CLCD_ASSERT_IMPL(a_one_side, req_ready, !bus_valid, "request taken while a command is offered")
	`CLCD_ASSERT(a_scan_end, (state_q == ST_SCAN_WR && bus_ready && sts.scan_done) |=> (state_q == ST_ADDR), "scroll did not end in an address set")
	`CLCD_ASSERT_IMPL(a_last_flag, bus_valid && (state_q == ST_HOME || state_q == ST_SCAN_WR), !cmd.last, "scroll command marked as last")

endmodule

>>> design/char_lcd_text_console.sv
// Top level of the character LCD text console.
// Depends on clcd_pkg, clcd_ctrl and clcd_dp.
//
// This block turns a stream of console requests (print a character, locate
// the cursor, clear the screen) into LCD bus commands: set display address,
// write data byte and clear display. Each request transaction on the req
// channel yields zero or more command transactions on the bus channel, and
// the final command of a request carries last_command. It handles one
// request at a time: a new request is taken only once every command of the
// previous one has been delivered. A plain character yields a data write,
// preceded by an address set when it follows a newline or a full row; a
// carriage return or a newline yields that address set alone or nothing; a
// locate yields an address set, a clear a clear command, the unused code none.
// A print past the last row scrolls the shadow screen store: each cell of
// the row below is read through the store's single read port, with its
// registered read data, then written back one row higher and offered on the
// bus, and the last row is blanked. A cell's display address is column +
// row * row_offset, taken modulo 256; the user writes row_offset through
// cfg_wr_en and cfg_wr_data while the block is idle (the block does not
// enforce this), and it resets to 64. After reset the store reads as all
// spaces at once, as per-cell valid bits stand in for a clearing pass.
module char_lcd_text_console
	import clcd_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [6:0] cfg_wr_data,
	input  logic       req_valid,
	output logic       req_ready,
	input  clcd_req_t  req,
	output logic       bus_valid,
	input  logic       bus_ready,
	output clcd_bus_t  bus
);

	clcd_cmd_t cmd;
	clcd_sts_t sts;

	// The controller sequences the commands; it sees only the request's
	// operation code and the datapath's status flags.
	clcd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_operation(req.operation),
		.sts          (sts),
		.bus_ready    (bus_ready),
		.req_ready    (req_ready),
		.bus_valid    (bus_valid),
		.cmd          (cmd)
	);

	// The datapath holds the cursor, the screen store and the row offset,
	// and forms the command payload that the controller selects.
	clcd_dp #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req        (req),
		.cmd        (cmd),
		.sts        (sts),
		.bus        (bus)
	);

endmodule

>>> tb/char_lcd_text_console_test.sv
// Self-checking testbench for char_lcd_text_console: console requests in, LCD bus commands out.
// Depends on clcd_pkg and the char_lcd_text_console RTL; it holds its own model of the console.
module char_lcd_text_console_test;
	import clcd_pkg::*;

	localparam int COLUMNS = COLUMNS_DEF;
	localparam int ROWS    = ROWS_DEF;
	localparam int CELLS   = COLUMNS * ROWS;
	// Idle wait, in clock cycles, after the last expected command; ample for any request to finish.
	localparam int SETTLE  = 4 * CELLS + 40;
	localparam int RANDOM_PER_PHASE = 112;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic [6:0] cfg_wr_data = 7'd0;
	logic       req_valid   = 1'b0;
	logic       req_ready;
	clcd_req_t  req         = '0;
	logic       bus_valid;
	logic       bus_ready   = 1'b0;
	clcd_bus_t  bus;

	char_lcd_text_console #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.bus_valid  (bus_valid),
		.bus_ready  (bus_ready),
		.bus        (bus)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Requests that are waiting to be offered, and the bus commands that the
	// console is expected to produce, oldest first.
	clcd_req_t req_pending[$];
	clcd_bus_t bus_expected[$];
	int        mismatches = 0;

	// Our own copy of the console state. The row can briefly exceed the last
	// row during a wrap, so it is kept as an int rather than at its port width.
	int         con_col;
	int         con_row;
	logic [7:0] con_prev;
	logic [7:0] con_screen [0:CELLS-1];
	logic [6:0] con_offset;

	// Pacing of both sides. In a calm stretch a side never idles; otherwise it
	// draws a random wait for every transaction.
	bit req_calm  = 1'b0;
	bit bus_calm  = 1'b0;
	int req_gap   = 0;
	int bus_stall = 0;

	function automatic logic [7:0] cell_address(int c, int r);
		int a;
		a = c + r * int'(con_offset);
		return a[7:0];
	endfunction

	function automatic void expect_command(logic [1:0] kind, logic [7:0] value);
		clcd_bus_t b;
		b.command_kind  = kind;
		b.command_value = value;
		b.last_command  = 1'b0;
		bus_expected.push_back(b);
	endfunction

	function automatic void blank_console();
		int i;
		con_col  = 0;
		con_row  = 0;
		con_prev = 8'd0;
		for (i = 0; i < CELLS; i++)
			con_screen[i] = BLANK;
	endfunction

	// Works out the bus commands of one accepted request and advances the
	// console state, marking the final command of the request.
	function automatic void console_predict(clcd_req_t r);
		int        before_count;
		int        i;
		clcd_bus_t tail;
		before_count = bus_expected.size();
		case (r.operation)
			OP_PRINT: begin
				// A pending newline or a full row moves the cursor to the next row first.
				if (con_prev == NEWLINE || con_col >= COLUMNS) begin
					con_col = 0;
					con_row++;
					if (con_row >= ROWS) begin
						// Scroll: shift the store up one row, blank the bottom row and
						// repaint the whole screen from the home address.
						for (i = 0; i < CELLS - COLUMNS; i++)
							con_screen[i] = con_screen[i + COLUMNS];
						for (i = CELLS - COLUMNS; i < CELLS; i++)
							con_screen[i] = BLANK;
						expect_command(KIND_ADDR, cell_address(0, 0));
						for (i = 0; i < CELLS; i++)
							expect_command(KIND_DATA, con_screen[i]);
						con_row = ROWS - 1;
					end
					expect_command(KIND_ADDR, cell_address(con_col, con_row));
				end
				// Newline and carriage return are never stored or written.
				if (r.char_code != NEWLINE && r.char_code != CRETURN) begin
					con_screen[con_col + con_row * COLUMNS] = r.char_code;
					expect_command(KIND_DATA, r.char_code);
					con_col++;
				end
				con_prev = r.char_code;
			end
			OP_LOCATE: begin
				con_col  = (int'(r.target_column) > COLUMNS) ? COLUMNS : int'(r.target_column);
				con_row  = (int'(r.target_row) > ROWS - 1) ? ROWS - 1 : int'(r.target_row);
				con_prev = 8'd0;
				expect_command(KIND_ADDR, cell_address(con_col, con_row));
			end
			OP_CLEAR: begin
				blank_console();
				expect_command(KIND_CLEAR, 8'd0);
			end
			default: ; // the unused operation code is ignored altogether
		endcase
		if (bus_expected.size() > before_count) begin
			tail = bus_expected.pop_back();
			tail.last_command = 1'b1;
			bus_expected.push_back(tail);
		end
	endfunction

	function automatic void queue_req(logic [1:0] op, logic [7:0] ch, logic [3:0] c, logic r);
		clcd_req_t t;
		t.operation     = op;
		t.char_code     = ch;
		t.target_column = c;
		t.target_row    = r;
		req_pending.push_back(t);
	endfunction

	// Random requests are mostly text with frequent newlines, so that rows fill,
	// wrap and scroll often; the rest are locates, clears, odd bytes and the
	// unused operation code. Unused fields still carry random bits.
	function automatic void queue_random_req();
		int         pick;
		logic [3:0] c;
		logic       r;
		logic [7:0] ch;
		pick = $urandom_range(0, 99);
		c    = 4'($urandom_range(0, 15));
		r    = 1'($urandom_range(0, 1));
		ch   = 8'($urandom_range(0, 255));
		if (pick < 62)
			queue_req(OP_PRINT, 8'($urandom_range(8'h20, 8'h7e)), c, r);
		else if (pick < 70)
			queue_req(OP_PRINT, ch, c, r);
		else if (pick < 80)
			queue_req(OP_PRINT, NEWLINE, c, r);
		else if (pick < 84)
			queue_req(OP_PRINT, CRETURN, c, r);
		else if (pick < 92)
			queue_req(OP_LOCATE, ch, c, r);
		else if (pick < 96)
			queue_req(OP_CLEAR, ch, c, r);
		else if (pick < 98)
			queue_req(2'b11, ch, c, r);
		else
			queue_req(OP_PRINT, 8'd0, c, r);
	endfunction

	// Request driver. Once a transaction is accepted, the next request either
	// follows at once, keeping valid high, or valid drops for the drawn gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				if ($urandom_range(0, 19) == 0)
					req_calm = !req_calm;
				req_gap = req_calm ? 0 : $urandom_range(0, 9);
				if (req_gap == 0 && req_pending.size() > 0) begin
					req <= req_pending.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end else if (!req_valid) begin
				if (req_gap > 0) begin
					req_gap--;
				end else if (req_pending.size() > 0) begin
					req       <= req_pending.pop_front();
					req_valid <= 1'b1;
				end
			end
		end
	end

	// Bus monitor. It follows register writes, checks each delivered command
	// against the oldest expectation, predicts the commands of each accepted
	// request, and paces bus_ready. Checking comes before prediction, so the
	// order of events inside one pass of the monitor never matters.
	always @(posedge clk) begin
		clcd_bus_t want;
		if (arst_n) begin
			if (cfg_wr_en)
				con_offset = cfg_wr_data;
			if (bus_valid && bus_ready) begin
				if (bus_expected.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected command: expected none, actual kind %0d value %02h last %0b",
						$time, bus.command_kind, bus.command_value, bus.last_command);
				end else begin
					want = bus_expected.pop_front();
					if (bus.command_kind !== want.command_kind) begin
						mismatches++;
						$display("%0t: command_kind: expected %0d, actual %0d",
							$time, want.command_kind, bus.command_kind);
					end
					if (bus.command_value !== want.command_value) begin
						mismatches++;
						$display("%0t: command_value: expected %02h, actual %02h",
							$time, want.command_value, bus.command_value);
					end
					if (bus.last_command !== want.last_command) begin
						mismatches++;
						$display("%0t: last_command: expected %0b, actual %0b",
							$time, want.last_command, bus.last_command);
					end
				end
				if ($urandom_range(0, 19) == 0)
					bus_calm = !bus_calm;
				bus_stall = bus_calm ? 0 : $urandom_range(0, 9);
			end
			if (req_valid && req_ready)
				console_predict(req);
		end
		// The stall counts down whether or not a command is on offer, so the
		// ready gaps land on every phase of the console's work.
		if (bus_stall > 0) begin
			bus_ready <= 1'b0;
			bus_stall--;
		end else begin
			bus_ready <= 1'b1;
		end
	end

	// Waits until every request has been taken and every command delivered,
	// then lets the console finish anything that produces no command.
	// Sampling on the falling edge keeps clear of the monitor's updates.
	task automatic wait_idle();
		while (req_pending.size() > 0 || req_valid || bus_expected.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_row_offset(logic [6:0] value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	initial begin
		logic [6:0] offsets [4];
		int         p;
		int         k;
		blank_console();
		con_offset = ROW_OFFSET_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, with the row offset still at its reset value.
		queue_req(OP_PRINT, 8'h48, 4'd0, 1'b0);
		queue_req(OP_PRINT, 8'h00, 4'd15, 1'b1);
		queue_req(OP_PRINT, 8'hff, 4'd0, 1'b0);
		queue_req(OP_PRINT, NEWLINE, 4'd0, 1'b0);
		queue_req(OP_PRINT, 8'h41, 4'd0, 1'b0);     // newline takes effect here
		queue_req(OP_PRINT, CRETURN, 4'd0, 1'b0);
		queue_req(OP_PRINT, NEWLINE, 4'd0, 1'b0);
		queue_req(OP_PRINT, 8'h42, 4'd0, 1'b0);     // wraps past the last row: scroll
		queue_req(OP_LOCATE, 8'hff, 4'd15, 1'b0);
		queue_req(OP_PRINT, 8'h43, 4'd0, 1'b0);
		queue_req(OP_PRINT, 8'h44, 4'd0, 1'b0);     // full top row wraps down
		queue_req(OP_LOCATE, 8'h00, 4'd15, 1'b1);
		queue_req(OP_PRINT, 8'h45, 4'd0, 1'b0);
		queue_req(OP_PRINT, 8'h46, 4'd0, 1'b0);     // full bottom row scrolls
		queue_req(2'b11, 8'hff, 4'd15, 1'b1);       // unused code, ignored
		queue_req(OP_PRINT, NEWLINE, 4'd0, 1'b0);
		queue_req(OP_PRINT, NEWLINE, 4'd0, 1'b0);   // newline after newline scrolls
		queue_req(OP_PRINT, CRETURN, 4'd0, 1'b0);   // and so does a return after it
		queue_req(OP_CLEAR, 8'hff, 4'd15, 1'b1);
		queue_req(OP_LOCATE, 8'h55, 4'd0, 1'b1);
		queue_req(OP_PRINT, 8'h7e, 4'd0, 1'b0);
		wait_idle();

		// Random phases, each under its own row offset, the extremes included.
		offsets[0] = 7'd0;
		offsets[1] = 7'd127;
		offsets[2] = 7'($urandom_range(1, 126));
		offsets[3] = 7'd1;
		for (p = 0; p < 4; p++) begin
			write_row_offset(offsets[p]);
			@(negedge clk);
			for (k = 0; k < RANDOM_PER_PHASE; k++)
				queue_random_req();
			wait_idle();
		end

		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Guard against a hung handshake; far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
